// ===== design/brb_pkg.sv =====
// shared types and constants for the byte ring buffer
package brb_pkg;

  // field widths fixed by the interface
  localparam int unsigned LEN_W  = 12;
  localparam int unsigned BYTE_W = 8;
  // read burst counter covers the largest get/peek length (64)
  localparam int unsigned RDL_W  = 7;
  // reported free space keeps this margin
  localparam int unsigned FREE_MARGIN = 10;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_QUERY = 2'd3
  } brb_cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NODATA  = 2'd2,
    ST_INVALID = 2'd3
  } brb_status_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [LEN_W-1:0]  req_len;
    logic              put_first;
    logic [BYTE_W-1:0] put_byte;
  } brb_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              last;
    logic [1:0]        status;
    logic [LEN_W-1:0]  data_len;
    logic [LEN_W-1:0]  free_len;
  } brb_out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic rd_last;
  } brb_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic             rd_go;
    logic [RDL_W-1:0] rd_len;
  } brb_sts_t;

endpackage

// ===== design/byte_ring_buffer_atomic.sv =====
// top level of the byte ring buffer with put, get, peek and length query
//
//  channel   ports                          handshake
//  -------   -----------------------------  -------------------------------------
//  input     start, busy, in_data           beat taken when start && !busy
//  result    out_strobe, out_data           beat valid for one cycle, no stall
//  config    cfg_valid, cfg_ready, cfg_data capacity written when valid && ready
//
//  put, query and every error answer: a new item can be taken straight away; the
//    result beat comes out of the result register in the cycle after the item is taken
//  get/peek of n bytes (n capped at MAX_READ): the bytes come out through the single
//    read port of the byte memory (one byte a cycle, read data registered)
//  busy stays high while a read burst runs; cfg_ready is always high
//  synchronous active-low reset clears pointers, count and put state; the
//    byte memory is not cleared (bytes are only read after being written)
module byte_ring_buffer_atomic #(
  parameter int unsigned STORE_DEPTH = 4096,
  parameter int unsigned MAX_READ    = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      start,
  output logic                      busy,
  input  brb_pkg::brb_in_t          in_data,
  // result channel
  output logic                      out_strobe,
  output brb_pkg::brb_out_t         out_data,
  // capacity register
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [brb_pkg::LEN_W-1:0] cfg_data
);
  import brb_pkg::*;

  brb_ctl_t ctl;
  brb_sts_t sts;
  logic     cfg_we;

  // capacity writes are to come only while idle; the block itself does not enforce it, and the port never holds off
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // controller decides when a beat is taken and runs read bursts
  brb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  // datapath holds ring state, the byte memory and the result register
  brb_dp #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_READ    (MAX_READ)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .ctl        (ctl),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

// ===== design/brb_ctrl.sv =====
// controller: accepts items and sequences read bursts for get and peek
module brb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  brb_pkg::brb_sts_t sts,
  output brb_pkg::brb_ctl_t ctl
);
  import brb_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t           state_r;
  logic [RDL_W-1:0] cnt_r;

  assign busy         = (state_r == S_READ);
  assign ctl.accept   = start && (state_r == S_IDLE);
  assign ctl.rd_issue = (state_r == S_READ);
  assign ctl.rd_last  = (state_r == S_READ) && (cnt_r == RDL_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (ctl.accept && sts.rd_go) begin
            state_r <= S_READ;
            cnt_r   <= sts.rd_len;
          end
        end
        S_READ: begin
          cnt_r <= cnt_r - RDL_W'(1);
          if (cnt_r == RDL_W'(1)) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
          cnt_r   <= '0;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (cnt_r != '0))
    else $error("read burst with zero count");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rd_last |=> (state_r == S_IDLE))
    else $error("burst did not end after last read");
  a_burst_load: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.accept && sts.rd_go) |=> (state_r == S_READ && cnt_r == $past(sts.rd_len)))
    else $error("burst length not loaded");
`endif

endmodule

// ===== design/brb_dp.sv =====
// datapath: ring pointers, byte count, byte memory and result registers
module brb_dp #(
  parameter int unsigned STORE_DEPTH = 4096,
  parameter int unsigned MAX_READ    = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  brb_pkg::brb_in_t           in_data,
  input  brb_pkg::brb_ctl_t          ctl,
  output brb_pkg::brb_sts_t          sts,
  input  logic                       cfg_we,
  input  logic [brb_pkg::LEN_W-1:0]  cfg_data,
  output logic                       out_strobe,
  output brb_pkg::brb_out_t          out_data
);
  import brb_pkg::*;

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  // ring length reaches 4096, so at least 13 bits
  localparam int unsigned CW = (AW > LEN_W + 1) ? AW : LEN_W + 1;
  localparam int unsigned MAX_CAP = (STORE_DEPTH - 1 < 4095) ? STORE_DEPTH - 1 : 4095;
  localparam logic [CW-1:0] RST_RING = CW'(MAX_CAP + 1);

  logic [BYTE_W-1:0] mem [STORE_DEPTH];

  logic [AW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt, rd_addr_r, rd_addr_nxt;
  logic [CW-1:0]     count_r, count_nxt, ring_r, ring_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic              drop_r, drop_nxt;
  logic              out_valid_r, out_valid_nxt, out_sel_r, out_sel_nxt;
  logic              out_last_r, out_last_nxt;
  logic [1:0]        out_st_r, out_st_nxt;
  logic [LEN_W-1:0]  out_dl_r, out_dl_nxt, out_fl_r, out_fl_nxt;
  logic [BYTE_W-1:0] mem_q_r;

  logic              mem_we;
  logic [CW-1:0]     cap_ext, cap_clamp, len_ext, free_sp, wp_inc, rd_inc, rp_sum, fl_base;
  logic [RDL_W-1:0]  rd_len;
  logic              is_read;

  assign cap_ext  = CW'(cfg_data);
  assign len_ext  = CW'(in_data.req_len);
  assign free_sp  = ring_r - CW'(1) - count_r;
  assign wp_inc   = CW'(wp_r) + CW'(1);
  assign rd_inc   = CW'(rd_addr_r) + CW'(1);
  assign rp_sum   = CW'(rp_r) + CW'(rd_len);
  assign fl_base  = count_r + CW'(FREE_MARGIN);
  assign rd_len   = (in_data.req_len > LEN_W'(MAX_READ)) ? RDL_W'(MAX_READ)
                                                       : in_data.req_len[RDL_W-1:0];
  assign is_read  = (in_data.cmd == CMD_GET) || (in_data.cmd == CMD_PEEK);

  always_comb begin
    if (cap_ext < CW'(2)) begin
      cap_clamp = CW'(2);
    end else if (cap_ext > CW'(MAX_CAP)) begin
      cap_clamp = CW'(MAX_CAP);
    end else begin
      cap_clamp = cap_ext;
    end
  end

  assign sts.rd_go  = is_read && (in_data.req_len != '0) && (count_r >= CW'(rd_len));
  assign sts.rd_len = rd_len;

  always_comb begin
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    rd_addr_nxt   = rd_addr_r;
    count_nxt     = count_r;
    ring_nxt      = ring_r;
    rem_nxt       = rem_r;
    drop_nxt      = drop_r;
    mem_we        = 1'b0;
    out_valid_nxt = 1'b0;
    out_sel_nxt   = 1'b0;
    out_last_nxt  = 1'b1;
    out_st_nxt    = ST_OK;
    out_dl_nxt    = '0;
    out_fl_nxt    = '0;
    if (cfg_we) begin
      ring_nxt  = cap_clamp + CW'(1);
      wp_nxt    = '0;
      rp_nxt    = '0;
      count_nxt = '0;
      rem_nxt   = '0;
      drop_nxt  = 1'b0;
    end else if (ctl.rd_issue) begin
      out_valid_nxt = 1'b1;
      out_sel_nxt   = 1'b1;
      out_last_nxt  = ctl.rd_last;
      rd_addr_nxt   = (rd_inc == ring_r) ? '0 : AW'(rd_inc);
    end else if (ctl.accept) begin
      case (in_data.cmd)
        CMD_PUT: begin
          out_valid_nxt = 1'b1;
          if (in_data.put_first) begin
            if (in_data.req_len == '0) begin
              rem_nxt    = '0;
              drop_nxt   = 1'b0;
              out_st_nxt = ST_INVALID;
            end else if (free_sp < len_ext) begin
              rem_nxt    = in_data.req_len - LEN_W'(1);
              drop_nxt   = 1'b1;
              out_st_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              wp_nxt    = (wp_inc == ring_r) ? '0 : AW'(wp_inc);
              count_nxt = count_r + CW'(1);
              rem_nxt   = in_data.req_len - LEN_W'(1);
              drop_nxt  = 1'b0;
            end
          end else if (rem_r == '0) begin
            out_st_nxt = ST_INVALID;
          end else begin
            rem_nxt = rem_r - LEN_W'(1);
            if (drop_r) begin
              out_st_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              wp_nxt    = (wp_inc == ring_r) ? '0 : AW'(wp_inc);
              count_nxt = count_r + CW'(1);
            end
            if (rem_r == LEN_W'(1)) begin
              drop_nxt = 1'b0;
            end
          end
        end
        CMD_QUERY: begin
          out_valid_nxt = 1'b1;
          out_dl_nxt    = count_r[LEN_W-1:0];
          out_fl_nxt    = (ring_r >= fl_base) ? LEN_W'(ring_r - fl_base) : '0;
        end
        default: begin
          // get or peek
          if (in_data.req_len == '0) begin
            out_valid_nxt = 1'b1;
            out_st_nxt    = ST_INVALID;
          end else if (!sts.rd_go) begin
            out_valid_nxt = 1'b1;
            out_st_nxt    = ST_NODATA;
          end else begin
            rd_addr_nxt = rp_r;
            if (in_data.cmd == CMD_GET) begin
              rp_nxt    = (rp_sum >= ring_r) ? AW'(rp_sum - ring_r) : AW'(rp_sum);
              count_nxt = count_r - CW'(rd_len);
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      count_r     <= '0;
      ring_r      <= RST_RING;
      rem_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      count_r     <= count_nxt;
      ring_r      <= ring_nxt;
      rem_r       <= rem_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    out_sel_r  <= out_sel_nxt;
    out_last_r <= out_last_nxt;
    out_st_r   <= out_st_nxt;
    out_dl_r   <= out_dl_nxt;
    out_fl_r   <= out_fl_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= in_data.put_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_issue) begin
      mem_q_r <= mem[rd_addr_r];
    end
  end

  assign out_strobe        = out_valid_r;
  assign out_data.data_out = out_sel_r ? mem_q_r : '0;
  assign out_data.last     = out_last_r;
  assign out_data.status   = out_st_r;
  assign out_data.data_len = out_dl_r;
  assign out_data.free_len = out_fl_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < ring_r)
    else $error("byte count reached ring length");
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(wp_r) < ring_r) && (CW'(rp_r) < ring_r))
    else $error("pointer outside ring");
  a_read_beat: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rd_issue |=> (out_valid_r && out_sel_r))
    else $error("memory read gave no result beat");
`endif

endmodule
